// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each macro expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/trfp_pkg.sv =====
// ----------------------------------------------------------------------------
// trfp_pkg
// Constants and types for the typed record field parser.
// ----------------------------------------------------------------------------
package trfp_pkg;

    localparam int NUMBER_WIDTH = 32;
    // numbers saturate at 2^min(NUMBER_WIDTH,32)-1, so that is all we store
    localparam int NUM_W  = (NUMBER_WIDTH >= 32) ? 32 : NUMBER_WIDTH;
    localparam int WIDE_W = NUM_W + 4;
    localparam int FIELD_W = 32;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam int         RADIX      = 10;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_TEXT   = 1'b1;

    typedef enum logic [6:0] {
        PH_TYPE     = 7'b0000001,
        PH_SKIP     = 7'b0000010,
        PH_VERSION  = 7'b0000100,
        PH_SCOPE    = 7'b0001000,
        PH_POSITION = 7'b0010000,
        PH_LENGTH   = 7'b0100000,
        PH_TEXT     = 7'b1000000
    } phase_t;

endpackage

// ===== hw/rtl/typed_record_field_parser.sv =====
// ----------------------------------------------------------------------------
// typed_record_field_parser
// Parses "T,num,...,len,text" records one byte per transfer and emits a
// header result followed by one result per text byte.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_in_byte
// m_       out  m_valid/m_ready    m_out_kind, m_rec_*, m_text_byte, m_last
//
// One byte per cycle while no result waits on a stalled output: the parse state updates at the input
// transfer and any result lands in the output register in the same edge.
// s_ready is low only while a result waits and m_ready is low.
// Reset (aresetn low, synchronous) returns the parser to waiting for a type
// byte and empties the output register.
`include "assert_macros.svh"

module typed_record_field_parser
    import trfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_out_kind,
    output logic [7:0]           m_rec_type,
    output logic [FIELD_W-1:0]   m_rec_version,
    output logic [FIELD_W-1:0]   m_rec_scope,
    output logic [FIELD_W-1:0]   m_rec_position,
    output logic [FIELD_W-1:0]   m_rec_length,
    output logic [7:0]           m_text_byte,
    output logic                 m_last
);

    phase_t             phase_reg, phase_next;
    logic [7:0]         type_reg, type_next;
    logic [NUM_W-1:0]   acc_reg, acc_next;
    logic [NUM_W-1:0]   version_reg, version_next;
    logic [NUM_W-1:0]   scope_reg, scope_next;
    logic [NUM_W-1:0]   position_reg, position_next;
    logic [NUM_W-1:0]   length_reg, length_next;
    logic [NUM_W-1:0]   remaining_reg, remaining_next;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [7:0]         out_type_reg;
    logic [NUM_W-1:0]   out_version_reg, out_scope_reg, out_position_reg, out_length_reg;
    logic [7:0]         out_text_reg;
    logic               out_last_reg;

    logic               in_fire;
    logic               res_load;
    logic               res_kind;
    logic [7:0]         res_text;
    logic               res_last;

    logic               is_ab, is_abd, is_comma, is_digit;
    logic [3:0]         digit;
    logic [WIDE_W-1:0]  acc_wide;
    logic [NUM_W-1:0]   acc_sat;
    logic [NUM_W-1:0]   remaining_dec;

    assign s_ready  = !out_valid_reg || m_ready;
    assign in_fire  = s_valid && s_ready;

    assign is_ab    = (type_reg == CHAR_A) || (type_reg == CHAR_B);
    assign is_abd   = is_ab || (type_reg == CHAR_D);
    assign is_comma = (s_in_byte == CHAR_COMMA);
    assign is_digit = (s_in_byte >= CHAR_ZERO) && (s_in_byte <= CHAR_NINE);
    assign digit    = is_digit ? 4'(s_in_byte - CHAR_ZERO) : 4'd0;

    // acc*10 + digit always fits in four extra bits; saturate on overflow
    assign acc_wide = WIDE_W'(acc_reg) * WIDE_W'(RADIX) + WIDE_W'(digit);
    assign acc_sat  = (acc_wide[WIDE_W-1:NUM_W] != 4'd0) ? {NUM_W{1'b1}}
                                                          : acc_wide[NUM_W-1:0];
    assign remaining_dec = remaining_reg - NUM_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        acc_next       = acc_reg;
        version_next   = version_reg;
        scope_next     = scope_reg;
        position_next  = position_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        res_load       = 1'b0;
        res_kind       = KIND_HEADER;
        res_text       = 8'd0;
        res_last       = 1'b0;

        case (phase_reg)
            PH_TYPE: begin
                type_next      = s_in_byte;
                version_next   = '0;
                scope_next     = '0;
                position_next  = '0;
                length_next    = '0;
                remaining_next = '0;
                acc_next       = '0;
                phase_next     = PH_SKIP;
            end
            PH_SKIP: begin
                acc_next   = '0;
                phase_next = is_abd ? PH_VERSION : PH_LENGTH;
            end
            PH_VERSION, PH_SCOPE, PH_POSITION: begin
                if (!is_comma) begin
                    acc_next = acc_sat;
                end else begin
                    acc_next = '0;
                    if (phase_reg == PH_VERSION) begin
                        version_next = acc_reg;
                        phase_next   = is_ab ? PH_SCOPE : PH_LENGTH;
                    end else if (phase_reg == PH_SCOPE) begin
                        scope_next = acc_reg;
                        phase_next = PH_POSITION;
                    end else begin
                        position_next = acc_reg;
                        phase_next    = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                if (!is_comma) begin
                    acc_next = acc_sat;
                end else begin
                    length_next    = acc_reg;
                    remaining_next = acc_reg;
                    acc_next       = '0;
                    res_load       = 1'b1;
                    res_last       = (acc_reg == '0);
                    phase_next     = (acc_reg == '0) ? PH_TYPE : PH_TEXT;
                end
            end
            PH_TEXT: begin
                remaining_next = remaining_dec;
                res_load       = 1'b1;
                res_kind       = KIND_TEXT;
                res_text       = s_in_byte;
                res_last       = (remaining_dec == '0);
                if (remaining_dec == '0) begin
                    phase_next = PH_TYPE;
                end
            end
            default: begin
                phase_next = PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TYPE;
            type_reg      <= '0;
            acc_reg       <= '0;
            version_reg   <= '0;
            scope_reg     <= '0;
            position_reg  <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            acc_reg       <= acc_next;
            version_reg   <= version_next;
            scope_reg     <= scope_next;
            position_reg  <= position_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
        end
    end

    // output register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= res_load;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register: payload
    always_ff @(posedge aclk) begin
        if (in_fire && res_load) begin
            out_kind_reg     <= res_kind;
            out_type_reg     <= type_next;
            out_version_reg  <= version_next;
            out_scope_reg    <= scope_next;
            out_position_reg <= position_next;
            out_length_reg   <= length_next;
            out_text_reg     <= res_text;
            out_last_reg     <= res_last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_kind     = out_kind_reg;
    assign m_rec_type     = out_type_reg;
    assign m_rec_version  = FIELD_W'(out_version_reg);
    assign m_rec_scope    = FIELD_W'(out_scope_reg);
    assign m_rec_position = FIELD_W'(out_position_reg);
    assign m_rec_length   = FIELD_W'(out_length_reg);
    assign m_text_byte    = out_text_reg;
    assign m_last         = out_last_reg;

    `ASSERT_SAME(a_text_has_bytes_left, phase_reg == PH_TEXT, remaining_reg != '0)
    `ASSERT_SAME(a_header_last_iff_empty, m_valid && (m_out_kind == KIND_HEADER), m_last == (m_rec_length == '0))
    `ASSERT_NEXT(a_last_returns_idle, in_fire && res_load && res_last, phase_reg == PH_TYPE)

endmodule
